>>> rtl/core/tti_pkg.sv
// Shared types and constants for the multi-radix text-to-integer converter.
// Used by tti_step and text_to_integer_multi_radix; depends on nothing else.

package tti_pkg;

	localparam int unsigned ValueWidth = 64;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_BLANK   = 3'd1,
		PH_HEXZERO = 3'd2,
		PH_DIGITS  = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		MODE_BIN = 2'd0,
		MODE_OCT = 2'd1,
		MODE_HEX = 2'd2,
		MODE_DEC = 2'd3
	} mode_t;

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowF  = 8'h66;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChLowX  = 8'h78;

	// Conversion state carried from one character to the next. For decimal
	// strings with a minus sign the accumulator holds the negated value.
	typedef struct packed {
		phase_t                  phase;
		mode_t                   mode;
		logic                    negative;
		logic [ValueWidth-1:0]   acc;
	} conv_state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

endpackage

>>> rtl/core/tti_step.sv
// Next-state logic of the converter: applies one character to the state.
// Depends on tti_pkg.

module tti_step
	import tti_pkg::*;
(
	input  conv_state_t cur,
	input  logic [1:0]  action,
	input  logic [7:0]  character,
	output conv_state_t nxt
);

	function automatic digit_t digit_decode(input mode_t m, input logic [7:0] c);
		digit_t d;
		logic   hex_ok;
		logic [7:0] v;
		d      = '0;
		hex_ok = 1'b0;
		v      = 8'd0;
		if (c >= ChZero && c <= ChNine) begin
			hex_ok = 1'b1;
			v      = c - ChZero;
		end else if (c >= ChUpA && c <= ChUpF) begin
			hex_ok = 1'b1;
			v      = c - ChUpA + 8'd10;
		end else if (c >= ChLowA && c <= ChLowF) begin
			hex_ok = 1'b1;
			v      = c - ChLowA + 8'd10;
		end
		d.val = v[3:0];
		case (m)
			MODE_BIN: d.ok = hex_ok && v < 8'd2;
			MODE_OCT: d.ok = hex_ok && v < 8'd8;
			MODE_HEX: d.ok = hex_ok;
			default:  d.ok = hex_ok && v < 8'd10;
		endcase
		return d;
	endfunction

	conv_state_t           eff;
	digit_t                dg;
	logic [ValueWidth-1:0] dig_ext;
	logic [ValueWidth-1:0] acc_dig;
	logic                  is_blank;

	assign is_blank = (character == ChSpace) || (character == ChTab);

	always_comb begin
		eff = cur;
		if (cur.phase == PH_START) begin
			eff.mode     = mode_t'(action);
			eff.acc      = '0;
			eff.negative = 1'b0;
			eff.phase    = PH_BLANK;
		end
	end

	assign dg      = digit_decode(eff.mode, character);
	assign dig_ext = eff.negative ? (ValueWidth'(0) - ValueWidth'(dg.val))
	                              : ValueWidth'(dg.val);

	// One digit step; a negative decimal run accumulates downward so that no
	// separate negation is needed when the result is given.
	always_comb begin
		case (eff.mode)
			MODE_BIN: acc_dig = {eff.acc[ValueWidth-2:0], dg.val[0]};
			MODE_OCT: acc_dig = {eff.acc[ValueWidth-4:0], dg.val[2:0]};
			MODE_HEX: acc_dig = {eff.acc[ValueWidth-5:0], dg.val};
			default:  acc_dig = {eff.acc[ValueWidth-4:0], 3'b000}
			                  + {eff.acc[ValueWidth-2:0], 1'b0} + dig_ext;
		endcase
	end

	always_comb begin
		nxt = eff;
		case (eff.phase)
			PH_BLANK: begin
				if (is_blank) begin
					nxt.phase = PH_BLANK;
				end else if (eff.mode == MODE_HEX && character == ChZero) begin
					nxt.phase = PH_HEXZERO;
				end else if (eff.mode == MODE_DEC &&
				             (character == ChPlus || character == ChMinus)) begin
					nxt.negative = (character == ChMinus);
					nxt.phase    = PH_DIGITS;
				end else if (dg.ok) begin
					nxt.acc   = acc_dig;
					nxt.phase = PH_DIGITS;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_HEXZERO: begin
				if (character == ChLowX || character == ChUpX) begin
					nxt.phase = PH_DIGITS;
				end else if (dg.ok) begin
					nxt.acc   = acc_dig;
					nxt.phase = PH_DIGITS;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (dg.ok) begin
					nxt.acc   = acc_dig;
					nxt.phase = PH_DIGITS;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			default: nxt.phase = PH_DONE;
		endcase
	end

endmodule

>>> rtl/core/text_to_integer_multi_radix.sv
// Top level of the multi-radix text-to-integer converter.
// Depends on tti_pkg and tti_step.

// A string arrives one character per transfer, the final character with
// s_tlast set; s_tuser on the first character picks binary, octal, hex or
// signed decimal. The block takes one character every cycle unless a last
// character waits on a pending result; each character passes an input
// register and then the update logic, whose longest path is the 64-bit
// multiply-by-ten-and-add of decimal mode. The 64-bit value of a string is
// registered on the master side as its last character leaves the input
// register. Input transfers continue while a result waits on the master
// side; only a following last character stalls until that result is taken.

module text_to_integer_multi_radix
	import tti_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] character
	input  logic [1:0]            s_tuser,   // [1:0] action
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ValueWidth-1:0] m_tdata    // [63:0] value
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic [1:0]  action_s1;
	logic        last_s1;
	logic        adv_s1;

	conv_state_t state_q;
	conv_state_t state_nxt;

	logic                  m_tvalid_q;
	logic [ValueWidth-1:0] m_tdata_q;

	// A non-last character never needs the output slot.
	assign adv_s1   = valid_s1 && !(last_s1 && m_tvalid_q && !m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1   <= s_tdata;
			action_s1 <= s_tuser;
			last_s1   <= s_tlast;
		end
	end

	tti_step u_step (
		.cur       (state_q),
		.action    (action_s1),
		.character (char_s1),
		.nxt       (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_START;
			state_q.mode     <= MODE_BIN;
			state_q.negative <= 1'b0;
			state_q.acc      <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				state_q.phase    <= PH_START;
				state_q.mode     <= state_nxt.mode;
				state_q.acc      <= '0;
				state_q.negative <= 1'b0;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			m_tdata_q <= state_nxt.acc;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (m_tvalid && state_q.phase == PH_START))
		else $error("last character did not produce a result");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(char_s1) && $stable(last_s1)))
		else $error("stalled input stage changed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(adv_s1 && last_s1))
		else $error("pending result overwritten");

endmodule

>>> tb/text_to_integer_multi_radix_tb.sv
`timescale 1ns / 1ps
// Testbench for text_to_integer_multi_radix: streams strings of characters in all
// four radix modes and checks every parsed 64-bit value against a built-in parser.
// Depends on tti_pkg and the text_to_integer_multi_radix RTL.

module text_to_integer_multi_radix_tb;
	import tti_pkg::*;

	// Tracks the parse state of the current string and holds the values
	// that completed strings must produce, oldest first.
	class value_scoreboard;
		phase_t                parse_phase;
		mode_t                 radix_mode;
		logic [ValueWidth-1:0] acc;
		logic                  minus;
		logic [ValueWidth-1:0] expected_values[$];
		int                    errors;

		function new();
			start_string();
			errors = 0;
		endfunction

		function void start_string();
			parse_phase = PH_START;
			acc = '0;
			minus = 1'b0;
		endfunction

		function void digit_or_stop(logic [7:0] ch);
			int  v;
			bit  ok;
			v = -1;
			if (ch >= ChZero && ch <= ChNine) v = int'(ch) - int'(ChZero);
			else if (ch >= ChUpA && ch <= ChUpF) v = int'(ch) - int'(ChUpA) + 10;
			else if (ch >= ChLowA && ch <= ChLowF) v = int'(ch) - int'(ChLowA) + 10;
			case (radix_mode)
				MODE_BIN: ok = (v >= 0 && v < 2);
				MODE_OCT: ok = (v >= 0 && v < 8);
				MODE_HEX: ok = (v >= 0);
				default:  ok = (v >= 0 && v < 10);
			endcase
			if (ok) begin
				case (radix_mode)
					MODE_BIN: acc = (acc << 1) + ValueWidth'(v);
					MODE_OCT: acc = (acc << 3) + ValueWidth'(v);
					MODE_HEX: acc = (acc << 4) + ValueWidth'(v);
					default:  acc = acc * 64'd10 + ValueWidth'(v);
				endcase
				parse_phase = PH_DIGITS;
			end else begin
				parse_phase = PH_DONE;
			end
		endfunction

		function void note_char(logic [1:0] action, logic [7:0] ch, logic last);
			if (parse_phase == PH_START) begin
				radix_mode = mode_t'(action);
				acc = '0;
				minus = 1'b0;
				parse_phase = PH_BLANK;
			end
			case (parse_phase)
				PH_BLANK: begin
					if (ch != ChSpace && ch != ChTab) begin
						if (radix_mode == MODE_HEX && ch == ChZero) begin
							parse_phase = PH_HEXZERO;
						end else if (radix_mode == MODE_DEC && (ch == ChPlus || ch == ChMinus)) begin
							minus = (ch == ChMinus);
							parse_phase = PH_DIGITS;
						end else begin
							digit_or_stop(ch);
						end
					end
				end
				PH_HEXZERO: begin
					if (ch == ChLowX || ch == ChUpX) parse_phase = PH_DIGITS;
					else digit_or_stop(ch);
				end
				PH_DIGITS: digit_or_stop(ch);
				default: parse_phase = PH_DONE;
			endcase
			if (last) begin
				expected_values.push_back(minus ? 64'd0 - acc : acc);
				start_string();
			end
		endfunction

		function void check_value(logic [ValueWidth-1:0] got);
			logic [ValueWidth-1:0] want;
			if (expected_values.size() == 0) begin
				$error("value: no result expected, actual %h", got);
				errors++;
			end else begin
				want = expected_values.pop_front();
				if (got !== want) begin
					$error("value: expected %h, actual %h", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_values.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic [1:0]            s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [ValueWidth-1:0] m_tdata;

	value_scoreboard sb = new();
	logic [7:0]      text_q[$];
	int              chars_sent;
	logic            no_idle;

	text_to_integer_multi_radix dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_char(s_tuser, s_tdata, s_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_value(m_tdata);
	end

	function automatic int draw_idle();
		return no_idle ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic logic [7:0] random_digit(mode_t md);
		int v;
		case (md)
			MODE_BIN: random_digit = ChZero + 8'($urandom_range(0, 1));
			MODE_OCT: random_digit = ChZero + 8'($urandom_range(0, 7));
			MODE_DEC: random_digit = ChZero + 8'($urandom_range(0, 9));
			default: begin
				v = $urandom_range(0, 21);
				if (v < 10) random_digit = ChZero + 8'(v);
				else if (v < 16) random_digit = ChUpA + 8'(v - 10);
				else random_digit = ChLowA + 8'(v - 16);
			end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_char(logic [1:0] action, logic [7:0] ch, logic last);
		int gap;
		gap = draw_idle();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= action;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
		@(negedge clk);
	endtask

	// The mode only counts on the first character, so later ones often carry another.
	task automatic send_text(mode_t md);
		logic [1:0] action;
		for (int i = 0; i < text_q.size(); i++) begin
			action = (i == 0 || $urandom_range(0, 1)) ? md : 2'($urandom_range(0, 3));
			send_char(action, text_q[i], i == text_q.size() - 1);
		end
	endtask

	task automatic load_text(string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	task automatic make_random_text(output mode_t md);
		int n;
		text_q.delete();
		md = mode_t'($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			repeat (n) text_q.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
			if (md == MODE_HEX && $urandom_range(0, 1)) begin
				text_q.push_back(ChZero);
				text_q.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
			end
			if (md == MODE_DEC && $urandom_range(0, 2) != 0)
				text_q.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
			// Long runs can make the accumulator wrap in every mode.
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 70) : $urandom_range(0, 8);
			repeat (n) text_q.push_back(random_digit(md));
			if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 4);
				repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int gap;
			gap = draw_idle();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		mode_t md;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		s_tlast    = 1'b0;
		no_idle    = 1'b0;
		chars_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		load_text("\t101");
		send_text(MODE_BIN);
		// A leading zero in octal is just a digit.
		load_text("077");
		send_text(MODE_OCT);
		// Hex prefix with nothing after it.
		load_text("0X");
		send_text(MODE_HEX);
		load_text("0xfF");
		send_text(MODE_HEX);
		// A byte above 127 stops the digits.
		load_text("-12");
		text_q.push_back(8'hFF);
		send_text(MODE_DEC);
		load_text(" ");
		send_text(MODE_DEC);
		// NUL stops accumulation before any digit.
		text_q.delete();
		text_q.push_back(8'h00);
		text_q.push_back(ChZero + 8'd1);
		send_text(MODE_BIN);
		load_text("+7");
		send_text(MODE_DEC);

		while (chars_sent < 750) begin
			if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
			make_random_text(md);
			send_text(md);
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/tti_pkg.sv
rtl/core/tti_step.sv
rtl/core/text_to_integer_multi_radix.sv
tb/text_to_integer_multi_radix_tb.sv
